// File: sv/bhke_pkg.sv
// Package: payload types and constants for the binary heap key engine.
package bhke_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int KEY_BITS_DEF = 64;

    typedef enum logic [3:0] {
        CMD_APPEND     = 4'd0,
        CMD_READOUT    = 4'd1,
        CMD_RESTART    = 4'd2,
        CMD_LENGTH     = 4'd3,
        CMD_BUILD_MAX  = 4'd4,
        CMD_BUILD_MIN  = 4'd5,
        CMD_SORT_MAX   = 4'd6,
        CMD_SORT_MIN   = 4'd7,
        CMD_PEEK_MAX   = 4'd8,
        CMD_PEEK_MIN   = 4'd9,
        CMD_INSERT_MAX = 4'd10,
        CMD_INSERT_MIN = 4'd11,
        CMD_CHECK_MIN  = 4'd12,
        CMD_CHECK_MAX  = 4'd13,
        CMD_DELETE_MAX = 4'd14,
        CMD_DELETE_MIN = 4'd15
    } t_cmd;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        logic [63:0] key;
    } t_in;

    typedef struct packed {
        logic [63:0] key_out;
        logic        key_valid;
        logic        heap_ok;
        logic [6:0]  length_out;
        logic [1:0]  status;
        logic        last;
    } t_out;

endpackage

// File: sv/binary_heap_key_engine.sv
// Top level: heap store in one synchronous memory with a sequencer for sift, sort and check.
//
// One command is taken at a time, and the next is accepted only after the last result beat of
// the current one has left. Readout reads the entries one at a time with one beat per entry,
// and a check compares one child-parent pair at a time. Build, sort, insert, delete and peek
// run through one memory read port. A sift-down level that swaps reads parent, left and right,
// compares left, compares right, then writes parent and child; a level that stops ends at the
// reads when the parent has no child, or after the compares. An insert runs a full build, a
// delete runs two builds, and a peek runs a full sort. Output stalls hold the sequencer at its
// result beat. The memory port sets the rate.
module binary_heap_key_engine #(
    parameter int CAPACITY = bhke_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = bhke_pkg::KEY_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bhke_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output bhke_pkg::t_out o_data
);
    import bhke_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_BUILD_INIT, S_SIFT_START, S_RD_P, S_RD_L, S_RD_R, S_CMP, S_CMP_R,
        S_WR_P, S_WR_C, S_PHASE_DONE, S_SORT_RD0, S_SORT_RDL, S_SORT_WR0,
        S_SORT_WRL, S_PEEK_RD, S_PEEK_WAIT, S_DEL_RD, S_DEL_WAIT, S_DEL_WR,
        S_CHK_RDC, S_CHK_RDP, S_CHK_CMP, S_CHK_EVAL, S_RO_RD, S_RO_WAIT, S_RO_EMIT, S_OUT
    } t_state;

    typedef enum logic [1:0] {
        J_BUILD, J_SORT, J_PEEK, J_DELETE
    } t_job;

    logic [KEY_BITS-1:0] r_mem [CAPACITY];
    logic [KEY_BITS-1:0] r_rdata;
    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_waddr;
    logic [KEY_BITS-1:0] w_wdata;
    logic                w_we;

    t_state              r_state;
    t_job                r_job;
    logic                r_max;
    logic                r_del2;
    logic [CW-1:0]       r_cnt;
    logic [6:0]          r_len;
    logic [CW-1:0]       r_n;
    logic [IW-1:0]       r_bi;
    logic [IW-1:0]       r_i;
    logic [IW-1:0]       r_best;
    logic [KEY_BITS-1:0] r_kp;
    logic [KEY_BITS-1:0] r_kb;
    logic [CW-1:0]       r_size;
    logic [CW-1:0]       r_j;
    logic [AW-1:0]       r_ra;
    logic                r_ovalid;
    t_out                r_out;
    t_out                n_out;
    logic                w_room;
    logic                w_emit;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    function automatic logic prec(input logic [KEY_BITS-1:0] a, input logic [KEY_BITS-1:0] b,
                                  input logic mx);
        return mx ? (a > b) : (a < b);
    endfunction

    logic [IW-1:0] w_l;
    logic [IW-1:0] w_r;
    assign w_l = IW'({r_i, 1'b1});
    assign w_r = IW'({r_i, 1'b0}) + IW'(2);

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign w_room = !r_ovalid || i_ready;
    assign w_emit = w_room && (r_state == S_OUT || r_state == S_RO_EMIT);

    always_comb begin
        n_out = '{key_out: '0, key_valid: 1'b0, heap_ok: 1'b0,
                  length_out: r_len, status: ST_OK, last: 1'b1};
        case (t_cmd'(i_data.command))
            CMD_APPEND: begin
                if (r_cnt >= CW'(CAPACITY)) n_out.status = ST_FULL;
            end
            CMD_RESTART: n_out.length_out = '0;
            CMD_BUILD_MAX, CMD_BUILD_MIN, CMD_SORT_MAX, CMD_SORT_MIN: begin
                n_out.length_out = 7'(r_cnt);
            end
            CMD_PEEK_MAX, CMD_PEEK_MIN: begin
                if (r_cnt == '0) n_out.status = ST_EMPTY;
            end
            CMD_INSERT_MAX, CMD_INSERT_MIN: begin
                if (r_cnt >= CW'(CAPACITY)) n_out.status = ST_FULL;
                else n_out.length_out = 7'(r_cnt + CW'(1));
            end
            CMD_CHECK_MIN, CMD_CHECK_MAX: n_out.heap_ok = (r_cnt <= CW'(1));
            CMD_DELETE_MAX, CMD_DELETE_MIN: begin
                if (r_cnt == '0) n_out.status = ST_EMPTY;
                else if (r_len != '0) n_out.length_out = r_len - 7'd1;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_raddr = r_ra;
        w_we    = 1'b0;
        w_waddr = AW'(0);
        w_wdata = r_kb;
        case (r_state)
            S_IDLE: begin
                w_we    = i_valid && o_ready && r_cnt < CW'(CAPACITY) &&
                          (i_data.command == CMD_APPEND || i_data.command == CMD_INSERT_MAX ||
                           i_data.command == CMD_INSERT_MIN);
                w_waddr = r_cnt[AW-1:0];
                w_wdata = i_data.key[KEY_BITS-1:0];
            end
            S_WR_P: begin
                w_we    = 1'b1;
                w_waddr = r_i[AW-1:0];
                w_wdata = r_kb;
            end
            S_WR_C: begin
                w_we    = 1'b1;
                w_waddr = r_best[AW-1:0];
                w_wdata = r_kp;
            end
            S_SORT_WR0: begin
                w_we    = 1'b1;
                w_waddr = AW'(0);
                w_wdata = r_rdata;
            end
            S_SORT_WRL: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_size - CW'(1));
                w_wdata = r_kp;
            end
            S_DEL_WR: begin
                w_we    = 1'b1;
                w_waddr = AW'(0);
                w_wdata = r_kb;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
            r_job    <= J_BUILD;
            r_max    <= 1'b0;
            r_del2   <= 1'b0;
        end else begin
            r_ovalid <= w_emit || (r_ovalid && !i_ready);
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_out  <= n_out;
                        r_max  <= (i_data.command == CMD_CHECK_MIN ||
                                   i_data.command == CMD_CHECK_MAX) ?
                                  i_data.command[0] : !i_data.command[0];
                        r_del2 <= 1'b0;
                        case (t_cmd'(i_data.command))
                            CMD_APPEND: begin
                                if (r_cnt < CW'(CAPACITY)) r_cnt <= r_cnt + CW'(1);
                                r_state <= S_OUT;
                            end
                            CMD_READOUT: begin
                                r_j     <= '0;
                                r_state <= (r_cnt == '0) ? S_OUT : S_RO_RD;
                            end
                            CMD_RESTART: begin
                                r_cnt <= '0;
                                r_len <= '0;
                                r_state <= S_OUT;
                            end
                            CMD_LENGTH: r_state <= S_OUT;
                            CMD_BUILD_MAX, CMD_BUILD_MIN, CMD_SORT_MAX, CMD_SORT_MIN: begin
                                r_job   <= i_data.command[1] ? J_SORT : J_BUILD;
                                r_len   <= 7'(r_cnt);
                                r_n     <= r_cnt;
                                r_state <= S_BUILD_INIT;
                            end
                            CMD_PEEK_MAX, CMD_PEEK_MIN: begin
                                if (r_cnt == '0) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_job <= J_PEEK;
                                    r_n   <= r_cnt;
                                    r_state <= S_BUILD_INIT;
                                end
                            end
                            CMD_INSERT_MAX, CMD_INSERT_MIN: begin
                                if (r_cnt >= CW'(CAPACITY)) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_cnt <= r_cnt + CW'(1);
                                    r_n   <= r_cnt + CW'(1);
                                    r_len <= 7'(r_cnt + CW'(1));
                                    r_job <= J_BUILD;
                                    r_state <= S_BUILD_INIT;
                                end
                            end
                            CMD_CHECK_MIN, CMD_CHECK_MAX: begin
                                r_j   <= CW'(1);
                                r_state <= (r_cnt <= CW'(1)) ? S_OUT : S_CHK_RDC;
                            end
                            default: begin
                                if (r_cnt == '0) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_job <= J_DELETE;
                                    r_n   <= r_cnt;
                                    r_state <= S_BUILD_INIT;
                                    if (r_len != '0) begin
                                        r_len <= r_len - 7'd1;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_BUILD_INIT: begin
                    r_bi    <= IW'(r_n >> 1);
                    r_size  <= r_n;
                    r_state <= (r_n == '0) ? S_PHASE_DONE : S_SIFT_START;
                end
                S_SIFT_START: begin
                    r_i     <= r_bi;
                    r_state <= (r_bi < IW'(r_n)) ? S_RD_P : S_PHASE_DONE;
                end
                S_RD_P: begin
                    r_ra    <= r_i[AW-1:0];
                    r_state <= S_RD_L;
                end
                S_RD_L: begin
                    r_ra    <= w_l[AW-1:0];
                    r_state <= S_RD_R;
                end
                S_RD_R: begin
                    r_kp    <= r_rdata;
                    r_kb    <= r_rdata;
                    r_best  <= r_i;
                    r_ra    <= w_r[AW-1:0];
                    r_state <= (w_l >= IW'(r_n)) ? S_PHASE_DONE : S_CMP;
                end
                S_CMP: begin
                    if (prec(r_rdata, r_kb, r_max)) begin
                        r_kb   <= r_rdata;
                        r_best <= w_l;
                    end
                    r_state <= S_CMP_R;
                end
                S_CMP_R: begin
                    if (w_r < IW'(r_n) && prec(r_rdata, r_kb, r_max)) begin
                        r_kb    <= r_rdata;
                        r_best  <= w_r;
                        r_state <= S_WR_P;
                    end else if (r_best == r_i) begin
                        r_state <= S_PHASE_DONE;
                    end else begin
                        r_state <= S_WR_P;
                    end
                end
                S_WR_P: r_state <= S_WR_C;
                S_WR_C: begin
                    r_i     <= r_best;
                    r_state <= S_RD_P;
                end
                S_PHASE_DONE: begin
                    if (r_bi != '0) begin
                        r_bi    <= r_bi - IW'(1);
                        r_state <= S_SIFT_START;
                    end else if (r_job == J_DELETE && !r_del2) begin
                        r_ra    <= AW'(r_n - CW'(1));
                        r_state <= S_DEL_RD;
                    end else if ((r_job == J_SORT || r_job == J_PEEK) && r_size > CW'(1)) begin
                        r_ra    <= AW'(0);
                        r_state <= S_SORT_RD0;
                    end else if (r_job == J_PEEK) begin
                        r_ra    <= AW'(r_cnt - CW'(1));
                        r_state <= S_PEEK_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SORT_RD0: begin
                    r_ra    <= AW'(r_size - CW'(1));
                    r_state <= S_SORT_RDL;
                end
                S_SORT_RDL: begin
                    r_kp    <= r_rdata;
                    r_state <= S_SORT_WR0;
                end
                S_SORT_WR0: r_state <= S_SORT_WRL;
                S_SORT_WRL: begin
                    r_size  <= r_size - CW'(1);
                    r_n     <= r_size - CW'(1);
                    r_i     <= '0;
                    r_bi    <= '0;
                    r_state <= S_RD_P;
                end
                S_PEEK_RD:   r_state <= S_PEEK_WAIT;
                S_PEEK_WAIT: begin
                    r_out.key_out   <= 64'(r_rdata);
                    r_out.key_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_DEL_RD:   r_state <= S_DEL_WAIT;
                S_DEL_WAIT: begin
                    r_kb    <= r_rdata;
                    r_state <= S_DEL_WR;
                end
                S_DEL_WR: begin
                    r_del2  <= 1'b1;
                    r_cnt   <= r_cnt - CW'(1);
                    r_n     <= r_n - CW'(1);
                    r_state <= S_BUILD_INIT;
                end
                S_CHK_RDC: begin
                    r_ra    <= AW'(r_j);
                    r_state <= S_CHK_RDP;
                end
                S_CHK_RDP: begin
                    r_ra    <= AW'((r_j - CW'(1)) >> 1);
                    r_state <= S_CHK_CMP;
                end
                S_CHK_CMP: begin
                    r_kp    <= r_rdata;
                    r_state <= S_CHK_EVAL;
                end
                S_CHK_EVAL: begin
                    if (prec(r_kp, r_rdata, r_max)) begin
                        r_state <= S_OUT;
                    end else if (r_j + CW'(1) >= r_cnt) begin
                        r_out.heap_ok <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_CHK_RDC;
                    end
                end
                S_RO_RD: begin
                    r_ra    <= AW'(r_j);
                    r_state <= S_RO_WAIT;
                end
                S_RO_WAIT: r_state <= S_RO_EMIT;
                S_RO_EMIT: begin
                    if (w_room) begin
                        r_out.key_out   <= 64'(r_rdata);
                        r_out.key_valid <= 1'b1;
                        r_out.last      <= (r_j + CW'(1) == r_cnt);
                        if (r_j + CW'(1) == r_cnt) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + CW'(1);
                            r_state <= S_RO_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (w_room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/bhke_checker.sv
// Checker: port-level properties of the binary heap key engine, with its bind.
module bhke_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input bhke_pkg::t_out o_data
);
    import bhke_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("beat dropped");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status != 2'd3) else $error("bad status");
    a_kv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> !o_data.key_valid) else $error("bad key_valid");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.length_out <= 7'd64) else $error("length range");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while beat pending");
endmodule

bind binary_heap_key_engine bhke_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);

// File: bench/binary_heap_key_engine_tb.sv
// Testbench: directed and random command streams against a behavioral heap predictor.
module binary_heap_key_engine_tb;
    import bhke_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 200000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   o_ready;
    t_in    i_data = '0;
    logic   o_valid;
    logic   i_ready = 1'b0;
    t_out   o_data;

    logic [63:0] heap_keys [CAP];
    int          heap_count;
    int          heap_length;
    t_out        pending_results [$];
    int          fail_count;
    int          result_count;
    int          cmd_count;
    int          idle_cycles = 0;
    bit          stall_enable;

    binary_heap_key_engine i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit ranks_higher(logic [63:0] a, logic [63:0] b, bit max_mode);
        return max_mode ? (a > b) : (a < b);
    endfunction

    function automatic void sift(int i, int n, bit max_mode);
        int l;
        int r;
        int best;
        logic [63:0] t;
        while (i < n) begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            best = i;
            if (l < n && ranks_higher(heap_keys[l], heap_keys[best], max_mode)) best = l;
            if (r < n && ranks_higher(heap_keys[r], heap_keys[best], max_mode)) best = r;
            if (best == i) break;
            t = heap_keys[i];
            heap_keys[i] = heap_keys[best];
            heap_keys[best] = t;
            i = best;
        end
    endfunction

    function automatic void heapify(int n, bit max_mode);
        for (int i = n / 2; i >= 0; i--) begin
            if (i < n) sift(i, n, max_mode);
        end
    endfunction

    function automatic void heap_sort(int n, bit max_mode);
        logic [63:0] t;
        heapify(n, max_mode);
        for (int s = n; s > 1; s--) begin
            t = heap_keys[0];
            heap_keys[0] = heap_keys[s - 1];
            heap_keys[s - 1] = t;
            sift(0, s - 1, max_mode);
        end
    endfunction

    function automatic void push_result(logic [63:0] k, bit v, bit ok, logic [1:0] st, bit lst);
        t_out r;
        r.key_out = k;
        r.key_valid = v;
        r.heap_ok = ok;
        r.length_out = heap_length[6:0];
        r.status = st;
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_command(t_in item);
        logic [63:0] res_key;
        bit          res_valid;
        bit          ok;
        logic [1:0]  st;
        bit          max_mode;
        res_key = '0;
        res_valid = 0;
        ok = 0;
        st = ST_OK;
        max_mode = 0;
        case (t_cmd'(item.command))
            CMD_APPEND: begin
                if (heap_count >= CAP) st = ST_FULL;
                else heap_keys[heap_count++] = item.key;
            end
            CMD_READOUT: begin
                if (heap_count > 0) begin
                    for (int i = 0; i < heap_count; i++)
                        push_result(heap_keys[i], 1, 0, ST_OK, i + 1 == heap_count);
                    return;
                end
            end
            CMD_RESTART: begin
                heap_count = 0;
                heap_length = 0;
            end
            CMD_LENGTH: ;
            CMD_BUILD_MAX, CMD_BUILD_MIN: begin
                heapify(heap_count, item.command == CMD_BUILD_MAX);
                heap_length = heap_count;
            end
            CMD_SORT_MAX, CMD_SORT_MIN: begin
                heap_sort(heap_count, item.command == CMD_SORT_MAX);
                heap_length = heap_count;
            end
            CMD_PEEK_MAX, CMD_PEEK_MIN: begin
                if (heap_count == 0) st = ST_EMPTY;
                else begin
                    heap_sort(heap_count, item.command == CMD_PEEK_MAX);
                    res_key = heap_keys[heap_count - 1];
                    res_valid = 1;
                end
            end
            CMD_INSERT_MAX, CMD_INSERT_MIN: begin
                if (heap_count >= CAP) st = ST_FULL;
                else begin
                    heap_keys[heap_count++] = item.key;
                    heapify(heap_count, item.command == CMD_INSERT_MAX);
                    heap_length = heap_count;
                end
            end
            CMD_CHECK_MIN, CMD_CHECK_MAX: begin
                ok = 1;
                max_mode = item.command == CMD_CHECK_MAX;
                for (int j = 1; j < heap_count; j++)
                    if (ranks_higher(heap_keys[j], heap_keys[(j - 1) / 2], max_mode)) ok = 0;
            end
            default: begin
                if (heap_count == 0) st = ST_EMPTY;
                else begin
                    max_mode = item.command == CMD_DELETE_MAX;
                    heapify(heap_count, max_mode);
                    heap_keys[0] = heap_keys[heap_count - 1];
                    heap_count--;
                    heapify(heap_count, max_mode);
                    if (heap_length > 0) heap_length--;
                end
            end
        endcase
        push_result(res_key, res_valid, ok, st, 1);
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    function automatic logic [63:0] rand_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'(4'($urandom_range(0, 15)));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_command(t_cmd cmd, logic [63:0] k);
        t_in item;
        int gap;
        item.command = cmd;
        item.key = k;
        gap = stall_enable ? gap_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        do @(posedge i_clk); while (!o_ready);
        predict_command(item);
        cmd_count++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            t_out exp_r;
            if (pending_results.size() == 0) begin
                $error("unexpected result key_out=%h", o_data.key_out);
                fail_count++;
            end else begin
                exp_r = pending_results.pop_front();
                result_count++;
                if (o_data.key_out !== exp_r.key_out) begin
                    $error("key_out exp %h got %h", exp_r.key_out, o_data.key_out);
                    fail_count++;
                end
                if (o_data.key_valid !== exp_r.key_valid) begin
                    $error("key_valid exp %b got %b", exp_r.key_valid, o_data.key_valid);
                    fail_count++;
                end
                if (o_data.heap_ok !== exp_r.heap_ok) begin
                    $error("heap_ok exp %b got %b", exp_r.heap_ok, o_data.heap_ok);
                    fail_count++;
                end
                if (o_data.length_out !== exp_r.length_out) begin
                    $error("length_out exp %0d got %0d", exp_r.length_out, o_data.length_out);
                    fail_count++;
                end
                if (o_data.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_data.status);
                    fail_count++;
                end
                if (o_data.last !== exp_r.last) begin
                    $error("last exp %b got %b", exp_r.last, o_data.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (!stall_enable) i_ready <= 1'b1;
            else if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                hold = gap_len();
                i_ready <= 1'b0;
            end else i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic test_empty_store();
        send_command(CMD_READOUT, '0);
        send_command(CMD_PEEK_MAX, '0);
        send_command(CMD_PEEK_MIN, '0);
        send_command(CMD_DELETE_MAX, '0);
        send_command(CMD_DELETE_MIN, '0);
        send_command(CMD_BUILD_MAX, '0);
        send_command(CMD_SORT_MIN, '0);
        send_command(CMD_CHECK_MAX, '0);
        send_command(CMD_LENGTH, '0);
    endtask

    task automatic test_each_command();
        send_command(CMD_APPEND, '1);
        send_command(CMD_APPEND, '0);
        send_command(CMD_APPEND, 64'h5555_AAAA_5555_AAAA);
        send_command(CMD_INSERT_MIN, 64'hAAAA_5555_AAAA_5555);
        send_command(CMD_CHECK_MIN, '0);
        send_command(CMD_CHECK_MAX, '0);
        send_command(CMD_BUILD_MAX, '0);
        send_command(CMD_CHECK_MAX, '0);
        send_command(CMD_INSERT_MAX, 64'h1);
        send_command(CMD_SORT_MAX, '0);
        send_command(CMD_READOUT, '0);
        send_command(CMD_PEEK_MAX, '0);
        send_command(CMD_PEEK_MIN, '0);
        send_command(CMD_BUILD_MIN, '0);
        send_command(CMD_DELETE_MIN, '0);
        send_command(CMD_DELETE_MAX, '0);
        send_command(CMD_SORT_MIN, '0);
        send_command(CMD_READOUT, '0);
        send_command(CMD_RESTART, '0);
        send_command(CMD_LENGTH, '0);
    endtask

    task automatic test_full_store();
        send_command(CMD_RESTART, '0);
        for (int i = 0; i < CAP; i++) send_command(CMD_APPEND, rand_key());
        send_command(CMD_APPEND, '1);
        send_command(CMD_INSERT_MAX, '1);
        send_command(CMD_SORT_MAX, '0);
        send_command(CMD_READOUT, '0);
        send_command(CMD_RESTART, '0);
    endtask

    task automatic test_random_commands(int n);
        t_cmd cmd;
        for (int i = 0; i < n; i++) begin
            stall_enable = (i % 80) >= 15;
            if (heap_count > 12 && $urandom_range(0, 3) == 0) cmd = CMD_RESTART;
            else if ($urandom_range(0, 2) == 0) cmd = CMD_APPEND;
            else cmd = t_cmd'($urandom_range(0, 15));
            send_command(cmd, rand_key());
        end
    endtask

    initial begin
        heap_count = 0;
        heap_length = 0;
        fail_count = 0;
        result_count = 0;
        cmd_count = 0;
        stall_enable = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_store();
        stall_enable = 1;
        test_each_command();
        test_full_store();
        test_random_commands(200);
        drain();
        $display("Covered %0d commands and %0d result beats, including empty and full store.",
                 cmd_count, result_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: binary_heap_key_engine.f
sv/bhke_pkg.sv
sv/binary_heap_key_engine.sv
sv/bhke_checker.sv
bench/binary_heap_key_engine_tb.sv
